FILE: hw/rtl/rmf_pkg.sv
// Shared types and constants for the RGB median filter.
// Used by the sort cell, the sort chain and the top level; no dependencies.
`timescale 1ns / 1ps

package rmf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_RADIUS = 3;

   localparam int CH_W = 8;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } rmf_ctl_type;

endpackage

FILE: hw/rtl/rmf_cell.sv
// One cell of the insertion sort chain: holds one channel value and its valid bit.
// Depends on rmf_pkg for the control struct.
`timescale 1ns / 1ps

module rmf_cell
   import rmf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rmf_ctl_type     ctl,
   input  logic [CH_W-1:0] din,
   input  logic [CH_W-1:0] left_val,
   input  logic            left_valid,
   input  logic            left_le,
   input  logic [CH_W-1:0] right_val,
   input  logic            right_valid,
   output logic [CH_W-1:0] val,
   output logic            valid,
   output logic            le
);

   logic [CH_W-1:0] val_ff, val_in;
   logic            valid_ff, valid_in;

   assign le    = valid_ff && (val_ff <= din);
   assign val   = val_ff;
   assign valid = valid_ff;

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.insert) begin
         if (!le) begin
            if (left_le) begin
               val_in   = din;
               valid_in = 1'b1;
            end else begin
               val_in   = left_val;
               valid_in = left_valid;
            end
         end
      end else if (ctl.shift) begin
         val_in   = right_val;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: hw/rtl/rmf_chain.sv
// Row of sort cells that keeps one channel's window values in ascending order.
// Depends on rmf_pkg and rmf_cell.
`timescale 1ns / 1ps

module rmf_chain
   import rmf_pkg::*;
#(
   parameter int CELLS = 49
)(
   input  logic            clock,
   input  logic            reset,
   input  rmf_ctl_type     ctl,
   input  logic [CH_W-1:0] din,
   output logic [CH_W-1:0] head
);

   logic [CH_W-1:0] val_w   [CELLS];
   logic            valid_w [CELLS];
   logic            le_w    [CELLS];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [CH_W-1:0] lv, rv;
      logic            lvalid, lle, rvalid;
      if (i == 0) begin : g_first
         assign lv     = '0;
         assign lvalid = 1'b1;
         assign lle    = 1'b1;
      end else begin : g_mid
         assign lv     = val_w[i-1];
         assign lvalid = valid_w[i-1];
         assign lle    = le_w[i-1];
      end
      if (i == CELLS - 1) begin : g_last
         assign rv     = '0;
         assign rvalid = 1'b0;
      end else begin : g_inner
         assign rv     = val_w[i+1];
         assign rvalid = valid_w[i+1];
      end
      rmf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .din         (din),
         .left_val    (lv),
         .left_valid  (lvalid),
         .left_le     (lle),
         .right_val   (rv),
         .right_valid (rvalid),
         .val         (val_w[i]),
         .valid       (valid_w[i]),
         .le          (le_w[i])
      );
   end

   assign head = val_w[0];

endmodule

FILE: hw/rtl/rgb_median_filter_2d.sv
// Top level of the streaming RGB median filter with line store and control.
// Depends on rmf_pkg and rmf_chain (which uses rmf_cell).
`timescale 1ns / 1ps

// Streaming RGB median filter over a square window of side 2*radius+1, clipped at
// the frame edges, with the upper median taken on an even count. Pixels enter in
// raster order and filtered pixels leave in raster order; drain transfers after
// the frame release the outputs still pending. One item is handled at a time. An
// item that releases an output is paced by the single read port of the line store,
// which feeds one pixel per cycle into three insertion sort chains, and by shifting
// the chains n/2 places to reach the median, n being the number of in-bounds window
// pixels (up to (2*MAX_RADIUS+1)^2). Any register write restarts the frame.

module rgb_median_filter_2d
   import rmf_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // red_in, green_in, blue_in
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // red_out, green_out, blue_out
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int RING  = 2 * MAX_RADIUS + 1;
   localparam int RGW   = $clog2(RING);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int RADW  = $clog2(MAX_RADIUS + 1);
   localparam int WIN   = RING * RING;
   localparam int NW    = $clog2(WIN + 1);
   localparam int DEPTH = 1 << (RGW + CW);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [10:0] cfg_w_ff, cfg_h_ff;
   logic [1:0]  cfg_r_ff;
   logic        cfg_wr;

   logic [WW-1:0]   eff_w;
   logic [RW-1:0]   eff_h;
   logic [RADW-1:0] eff_r;
   logic [CW-1:0]   w_last;
   logic [RW-1:0]   h_last;

   logic [2:0]     state_ff, state_in;
   logic [CW-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RGW-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic           in_full_ff, in_full_in;

   logic [RW-1:0]  y_ff, y_in, y_end_ff, y_end_in;
   logic [CW-1:0]  x_ff, x_in, x_start_ff, x_start_in, x_end_ff, x_end_in;
   logic [RGW-1:0] yring_ff, yring_in;
   logic [NW-1:0]  n_ff, n_in, shcnt_ff, shcnt_in;
   logic           rd_vld_ff;
   logic [23:0]    rd_data_ff;
   logic [23:0]    mem [DEPTH];

   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic           accept, store;
   logic [RW:0]    tr_sum;
   logic [CW:0]    tc_sum;
   logic [RW-1:0]  tr, r0;
   logic [CW-1:0]  tc, c0;
   logic [RGW-1:0] row_back, ring_start;
   logic           ready, out_ok, last_pos, load;
   rmf_ctl_type    ctl;
   logic [CH_W-1:0] med_r, med_g, med_b;

   function automatic logic [RGW-1:0] ring_next(input logic [RGW-1:0] v);
      ring_next = (v == RGW'(RING - 1)) ? '0 : v + 1'b1;
   endfunction

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= 11'd1024;
         cfg_h_ff <= 11'd1024;
         cfg_r_ff <= 2'd1;
      end else if (cfg_wr) begin
         unique case (csr_paddr[3:2])
            REG_IMAGE_WIDTH:   cfg_w_ff <= csr_pwdata[10:0];
            REG_IMAGE_HEIGHT:  cfg_h_ff <= csr_pwdata[10:0];
            REG_WINDOW_RADIUS: cfg_r_ff <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_IMAGE_WIDTH:   csr_prdata = 32'(cfg_w_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = 32'(cfg_h_ff);
         REG_WINDOW_RADIUS: csr_prdata = 32'(cfg_r_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (cfg_w_ff == 11'd0) eff_w = WW'(1);
      else if (32'(cfg_w_ff) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
      else eff_w = WW'(cfg_w_ff);
      if (cfg_h_ff == 11'd0) eff_h = RW'(1);
      else if (32'(cfg_h_ff) > MAX_HEIGHT) eff_h = RW'(MAX_HEIGHT);
      else eff_h = RW'(cfg_h_ff);
      if (32'(cfg_r_ff) > MAX_RADIUS) eff_r = RADW'(MAX_RADIUS);
      else eff_r = RADW'(cfg_r_ff);
   end

   assign w_last = CW'(eff_w - 1'b1);
   assign h_last = eff_h - 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign store      = accept && (req_tuser == FUNC_PIXEL) && !in_full_ff &&
                       (in_row_ff < eff_h) && (in_col_ff <= w_last);

   // Window bounds of the next output position.
   always_comb begin
      tr_sum     = {1'b0, out_row_ff} + (RW+1)'(eff_r);
      tc_sum     = {1'b0, out_col_ff} + (CW+1)'(eff_r);
      tr         = (tr_sum > (RW+1)'(h_last)) ? h_last : RW'(tr_sum);
      tc         = (tc_sum > (CW+1)'(w_last)) ? w_last : CW'(tc_sum);
      r0         = (out_row_ff >= RW'(eff_r)) ? out_row_ff - RW'(eff_r) : '0;
      c0         = (out_col_ff >= CW'(eff_r)) ? out_col_ff - CW'(eff_r) : '0;
      row_back   = RGW'(out_row_ff - r0);
      ring_start = (out_ring_ff >= row_back) ? out_ring_ff - row_back
                                             : out_ring_ff + RGW'(RING) - row_back;
      ready      = in_full_ff || (in_row_ff > tr) ||
                   ((in_row_ff == tr) && (in_col_ff > tc));
      out_ok     = (out_row_ff <= h_last) && (out_col_ff <= w_last);
      last_pos   = (out_row_ff == h_last) && (out_col_ff == w_last);
   end

   assign load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in    = state_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      in_full_in  = in_full_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      y_in        = y_ff;
      y_end_in    = y_end_ff;
      x_in        = x_ff;
      x_start_in  = x_start_ff;
      x_end_in    = x_end_ff;
      yring_in    = yring_ff;
      n_in        = n_ff;
      shcnt_in    = shcnt_ff;
      ctl         = '0;

      if (store) begin
         if (in_col_ff == w_last) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 1'b1;
            in_ring_in = ring_next(in_ring_ff);
            if (in_row_ff == h_last) in_full_in = 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ctl.clear  = 1'b1;
            y_in       = r0;
            y_end_in   = tr;
            x_in       = c0;
            x_start_in = c0;
            x_end_in   = tc;
            yring_in   = ring_start;
            n_in       = '0;
            state_in   = (out_ok && ready) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            n_in = n_ff + 1'b1;
            if (x_ff == x_end_ff) begin
               x_in = x_start_ff;
               if (y_ff == y_end_ff) begin
                  state_in = ST_WAIT;
               end else begin
                  y_in     = y_ff + 1'b1;
                  yring_in = ring_next(yring_ff);
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            shcnt_in = n_ff >> 1;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (shcnt_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               ctl.shift = 1'b1;
               shcnt_in  = shcnt_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (load) begin
               state_in = ST_IDLE;
               if (last_pos) begin
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_ring_in  = '0;
                  in_full_in  = 1'b0;
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_ring_in = '0;
               end else if (out_col_ff == w_last) begin
                  out_col_in  = '0;
                  out_row_in  = out_row_ff + 1'b1;
                  out_ring_in = ring_next(out_ring_ff);
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      ctl.insert = rd_vld_ff;

      if (cfg_wr) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_ring_in  = '0;
         in_full_in  = 1'b0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_ring_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {med_b, med_g, med_r};
         rsp_last_in  = last_pos;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         in_full_ff   <= 1'b0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_ring_ff  <= '0;
         n_ff         <= '0;
         shcnt_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_ring_ff   <= in_ring_in;
         in_full_ff   <= in_full_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_ring_ff  <= out_ring_in;
         n_ff         <= n_in;
         shcnt_ff     <= shcnt_in;
         rd_vld_ff    <= (state_ff == ST_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff        <= y_in;
      y_end_ff    <= y_end_in;
      x_ff        <= x_in;
      x_start_ff  <= x_start_in;
      x_end_ff    <= x_end_in;
      yring_ff    <= yring_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Line store: a ring of rows, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (store) begin
         mem[{in_ring_ff, in_col_ff}] <= req_tdata;
      end
      rd_data_ff <= mem[{yring_ff, x_ff}];
   end

   rmf_chain #(.CELLS(WIN)) u_chain_r (
      .clock (clock), .reset (reset), .ctl (ctl),
      .din (rd_data_ff[7:0]), .head (med_r)
   );
   rmf_chain #(.CELLS(WIN)) u_chain_g (
      .clock (clock), .reset (reset), .ctl (ctl),
      .din (rd_data_ff[15:8]), .head (med_g)
   );
   rmf_chain #(.CELLS(WIN)) u_chain_b (
      .clock (clock), .reset (reset), .ctl (ctl),
      .din (rd_data_ff[23:16]), .head (med_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_insert_shift: assert property (@(posedge clock) disable iff (reset)
      !(ctl.insert && ctl.shift))
      else $error("sort chain asked to insert and shift together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(WIN))
      else $error("window count exceeds chain length");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted transfer not followed by window check");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (in_row_ff <= eff_h))
      else $error("input row beyond frame height");

endmodule
